/* rtl/dns_qname_label_encoder_core_assert.svh */
// Assertion macros shared by the label encoder modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DNS_QNAME_LABEL_ENCODER_CORE_ASSERT_SVH
`define DNS_QNAME_LABEL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dqle_pkg.sv */
// Package for the DNS QNAME label encoder: constants and the result type.
// Depends on nothing; used by the RTL modules and the testbench.
package dqle_pkg;

    localparam int unsigned MAX_CAPACITY = 1024;
    localparam logic [10:0] CapResetValue = 11'd512;
    localparam logic [5:0]  LabelMax      = 6'd63;
    localparam logic [7:0]  DotCode       = 8'd46;
    localparam logic [7:0]  TermCode      = 8'd0;
    localparam int unsigned FifoDepth     = 4;

    // One result item
    typedef struct packed {
        logic        write_valid;
        logic [9:0]  write_address;
        logic [7:0]  write_data;
        logic        name_done;
        logic        status;
        logic [10:0] encoded_length;
    } t_result;

    // Results produced by one accepted input beat (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

/* rtl/dqle_if.sv */
// Handshake channel interfaces of the label encoder: input, result, config.
// Depends on nothing.
interface dqle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface dqle_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [9:0]  write_address;
    logic [7:0]  write_data;
    logic        name_done;
    logic        status;
    logic [10:0] encoded_length;
    modport source (output valid, output write_valid, output write_address,
                    output write_data, output name_done, output status,
                    output encoded_length, input ready);
    modport sink   (input valid, input write_valid, input write_address,
                    input write_data, input name_done, input status,
                    input encoded_length, output ready);
endinterface

interface dqle_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dns_qname_label_encoder_core.sv */
// Top level of the DNS QNAME label encoder.
// Depends on dqle_pkg, dqle_if, dqle_encode and dqle_fifo.
//
// Usage:
//   i_in carries one hostname byte a beat; '.' separates labels, zero ends
//   the name. o_out carries position-addressed buffer writes: each character
//   at its place, a length byte per label, and on the terminator the closing
//   zero with name_done, status and the encoded length (or a lone failure
//   result). i_cfg writes buffer_capacity and is always ready; the user must
//   write it only while the block is idle, which the block does not enforce.
// Order: a byte's results enter the result queue on the edge that accepts
//   its beat and are offered from there in the order they were produced.
// Throughput: one input byte per cycle while the queue has room, set by
//   the label-state encode step; a successful terminator adds one beat.
// Reset: clears name state and the result queue; capacity returns to 512.
// Stall: results wait in a four-entry queue; i_in.ready drops while fewer
//   than two queue entries are free, so nothing is lost.
module dns_qname_label_encoder_core
    import dqle_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dqle_in_if.sink     i_in,
    dqle_cfg_if.sink    i_cfg,
    dqle_out_if.source  o_out
);

    logic [10:0] r_capacity;
    logic        accept;
    logic        room;
    t_push       push_raw;
    t_push       push;
    t_result     head;

    // Hold the capacity register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapResetValue;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    dqle_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char     (i_in.char_code),
        .i_capacity (r_capacity),
        .o_push     (push_raw)
    );

    // Drop results unless the beat is accepted
    always_comb begin
        push = push_raw;
        if (!accept) begin
            push.count = 2'd0;
        end
    end

    dqle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_head  (head)
    );

    assign o_out.write_valid    = head.write_valid;
    assign o_out.write_address  = head.write_address;
    assign o_out.write_data     = head.write_data;
    assign o_out.name_done      = head.name_done;
    assign o_out.status         = head.status;
    assign o_out.encoded_length = head.encoded_length;

endmodule

/* rtl/dqle_encode.sv */
// Per-name encoder state and the single-pass logic that turns one hostname
// byte into its result items. Depends on dqle_pkg and the assertion header.
`include "dns_qname_label_encoder_core_assert.svh"

module dqle_encode
    import dqle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_char,
    input  logic [10:0] i_capacity,
    output t_push       o_push
);

    logic [10:0] r_start;
    logic [5:0]  r_len;
    logic        r_err;
    logic [10:0] n_start;
    logic [5:0]  n_len;
    logic        n_err;

    logic [10:0] cap_eff;
    logic [11:0] sum_next;
    logic [11:0] sum_term;
    logic        term_fail;

    // Saturate the capacity and form the candidate positions
    always_comb begin
        cap_eff   = (i_capacity > 11'(MAX_CAPACITY)) ? 11'(MAX_CAPACITY) : i_capacity;
        sum_next  = {1'b0, r_start} + {6'd0, r_len} + 12'd1;
        sum_term  = sum_next + 12'd1;
        term_fail = r_err || (r_len == 6'd0) || (sum_term > {1'b0, cap_eff});
    end

    // Decide the results and the next state for this beat
    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_err   = r_err;
        o_push  = '0;
        if (i_char == TermCode) begin
            n_start = '0;
            n_len   = '0;
            n_err   = 1'b0;
            if (term_fail) begin
                o_push.count          = 2'd1;
                o_push.res0.name_done = 1'b1;
                o_push.res0.status    = 1'b1;
            end else begin
                o_push.count                = 2'd2;
                o_push.res0.write_valid     = 1'b1;
                o_push.res0.write_address   = r_start[9:0];
                o_push.res0.write_data      = {2'b00, r_len};
                o_push.res1.write_valid     = 1'b1;
                o_push.res1.write_address   = sum_next[9:0];
                o_push.res1.name_done       = 1'b1;
                o_push.res1.encoded_length  = sum_term[10:0];
            end
        end else if (!r_err) begin
            if (i_char == DotCode) begin
                if ((r_len == 6'd0) || (sum_next >= {1'b0, cap_eff})) begin
                    n_err = 1'b1;
                end else begin
                    o_push.count              = 2'd1;
                    o_push.res0.write_valid   = 1'b1;
                    o_push.res0.write_address = r_start[9:0];
                    o_push.res0.write_data    = {2'b00, r_len};
                    n_start = sum_next[10:0];
                    n_len   = '0;
                end
            end else begin
                if ((r_len >= LabelMax) || (sum_next >= {1'b0, cap_eff})) begin
                    n_err = 1'b1;
                end else begin
                    o_push.count              = 2'd1;
                    o_push.res0.write_valid   = 1'b1;
                    o_push.res0.write_address = sum_next[9:0];
                    o_push.res0.write_data    = i_char;
                    n_len = r_len + 6'd1;
                end
            end
        end
    end

    // Advance the per-name state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_len   <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_start <= n_start;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

    `DQLE_ASSERT_NOW(a_len_max, i_clk, i_rst_n, 1'b1, r_len <= LabelMax, "label length above 63")
    `DQLE_ASSERT_NEXT(a_term_clear, i_clk, i_rst_n, i_accept && (i_char == TermCode), (r_start == 11'd0) && (r_len == 6'd0) && !r_err, "name state not cleared after terminator")
    `DQLE_ASSERT_NOW(a_start_in_cap, i_clk, i_rst_n, 1'b1, r_start < 11'(MAX_CAPACITY), "label start beyond maximum capacity")

endmodule

/* rtl/dqle_fifo.sv */
// Result queue of the label encoder: takes up to two results per cycle and
// hands out one per beat. Depends on dqle_pkg and the assertion header.
`include "dns_qname_label_encoder_core_assert.svh"

module dqle_fifo
    import dqle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    localparam int unsigned PtrW = $clog2(FifoDepth);

    t_result             r_mem [FifoDepth];
    logic [PtrW-1:0]     r_wr;
    logic [PtrW-1:0]     r_rd;
    logic [PtrW:0]       r_count;
    logic [PtrW-1:0]     wr_next;
    logic                do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign wr_next = r_wr + PtrW'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // Room for a two-result beat
    assign o_room  = (r_count <= (PtrW + 1)'(FifoDepth - 2));

    // Write the pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PtrW'(i_push.count);
            r_rd    <= r_rd + PtrW'(do_pop);
            r_count <= r_count + (PtrW + 1)'(i_push.count) - (PtrW + 1)'(do_pop);
        end
    end

    `DQLE_ASSERT_NOW(a_no_overfill, i_clk, i_rst_n, 1'b1, r_count <= (PtrW + 1)'(FifoDepth), "result queue over its depth")
    `DQLE_ASSERT_NOW(a_push_room, i_clk, i_rst_n, i_push.count != 2'd0, o_room, "results pushed without room")
    `DQLE_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, 1'b1, r_count == $past(r_count) + (PtrW + 1)'($past(i_push.count)) - (PtrW + 1)'($past(do_pop)), "queue occupancy lost track")

endmodule

/* bench/tb_dns_qname_label_encoder_core.sv */
// Testbench for dns_qname_label_encoder_core: drives hostname bytes, predicts each
// buffer write, length byte and terminator result, and checks every output beat.
// Depends on dqle_pkg, dqle_if and the RTL of the block.
module tb_dns_qname_label_encoder_core;
    import dqle_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 350;
    localparam int QUIET_ITEMS   = 120;
    localparam int PHASE_ITEMS   = 70;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;

    dqle_in_if  in_if ();
    dqle_cfg_if cfg_if ();
    dqle_out_if out_if ();

    dns_qname_label_encoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Encoder state as the bench sees it
    logic [10:0] capacity;
    int unsigned seg_base;
    int unsigned seg_chars;
    bit          name_failed;

    t_result pending_writes[$];
    int      failures;
    int      counted_items;
    int      cycle_count;
    bit      gaps_on;
    bit      stall_on;

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Work out the results of one accepted byte and queue them
    function automatic void encode_char(logic [7:0] c);
        int unsigned eff_cap;
        int unsigned pos;
        t_result     r;
        eff_cap = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;
        r = '0;
        if (c == TermCode) begin
            if (name_failed || seg_chars == 0 || seg_base + seg_chars + 2 > eff_cap) begin
                r.name_done = 1'b1;
                r.status    = 1'b1;
                pending_writes.push_back(r);
            end else begin
                r.write_valid   = 1'b1;
                r.write_address = 10'(seg_base);
                r.write_data    = 8'(seg_chars);
                pending_writes.push_back(r);
                r.write_address  = 10'(seg_base + 1 + seg_chars);
                r.write_data     = 8'd0;
                r.name_done      = 1'b1;
                r.encoded_length = 11'(seg_base + seg_chars + 2);
                pending_writes.push_back(r);
            end
            seg_base    = 0;
            seg_chars   = 0;
            name_failed = 1'b0;
            return;
        end
        // bytes after an error are swallowed
        if (name_failed)
            return;
        pos = seg_base + 1 + seg_chars;
        if (c == DotCode) begin
            if (seg_chars == 0 || pos >= eff_cap) begin
                name_failed = 1'b1;
                return;
            end
            r.write_valid   = 1'b1;
            r.write_address = 10'(seg_base);
            r.write_data    = 8'(seg_chars);
            pending_writes.push_back(r);
            seg_base  = pos;
            seg_chars = 0;
            return;
        end
        if (seg_chars >= LabelMax || pos >= eff_cap) begin
            name_failed = 1'b1;
            return;
        end
        r.write_valid   = 1'b1;
        r.write_address = 10'(pos);
        r.write_data    = c;
        pending_writes.push_back(r);
        seg_chars++;
    endfunction

    function automatic void compare_field(string field, logic [10:0] want, logic [10:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            failures++;
        end
    endfunction

    // Check each result beat against the oldest expectation
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual addr %0d data %0d",
                         $time, out_if.write_address, out_if.write_data);
                failures++;
            end else begin
                want = pending_writes.pop_front();
                compare_field("write_valid", 11'(want.write_valid),
                              11'(out_if.write_valid));
                compare_field("write_address", 11'(want.write_address),
                              11'(out_if.write_address));
                compare_field("write_data", 11'(want.write_data),
                              11'(out_if.write_data));
                compare_field("name_done", 11'(want.name_done),
                              11'(out_if.name_done));
                compare_field("status", 11'(want.status), 11'(out_if.status));
                compare_field("encoded_length", want.encoded_length, out_if.encoded_length);
            end
        end
    end

    // Stall the result channel in random bursts
    initial begin : result_stall
        int burst;
        burst = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_on && burst == 0 && $urandom_range(0, 7) == 0)
                burst = $urandom_range(1, 9);
            if (burst > 0) begin
                out_if.ready <= 1'b0;
                burst--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Send one byte; valid is left high so the next beat can follow directly
    task automatic send_char(logic [7:0] c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= c;
        do @(posedge clk); while (!in_if.ready);
        counted_items++;
        encode_char(c);
    endtask

    task automatic send_name(string s);
        foreach (s[i]) send_char(s[i]);
        send_char(TermCode);
    endtask

    // Drop valid, wait for every expected beat, then let the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [10:0] value);
        drain_results();
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        capacity = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Any byte that is neither a dot nor the terminator
    function automatic logic [7:0] label_byte();
        int v;
        v = $urandom_range(1, 254);
        if (v >= DotCode)
            v++;
        return 8'(v);
    endfunction

    function automatic logic [10:0] pick_capacity(int phase);
        if (phase == 0)
            return 11'(MAX_CAPACITY);
        case ($urandom_range(0, 3))
            0: return 11'($urandom_range(2, 24));
            1: return 11'($urandom_range(25, 200));
            2: return 11'($urandom_range(201, 2047));
            default: return ($urandom_range(0, 1) == 0) ? CapResetValue : 11'h7FF;
        endcase
    endfunction

    // Mostly well-formed names with random content; the rest broken or noise
    task automatic send_random_name();
        int kind;
        int labels;
        int len;
        int defect;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            labels = $urandom_range(1, 4);
            for (int l = 0; l < labels; l++) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(62, 65)
                                                   : $urandom_range(1, 12);
                if (l > 0)
                    send_char(DotCode);
                repeat (len) send_char(label_byte());
            end
            send_char(TermCode);
        end else if (kind == 7) begin
            // leading dot, double dot or trailing dot
            defect = $urandom_range(0, 2);
            if (defect == 0)
                send_char(DotCode);
            repeat ($urandom_range(1, 6)) send_char(label_byte());
            if (defect != 0)
                send_char(DotCode);
            if (defect == 1) begin
                send_char(DotCode);
                repeat ($urandom_range(1, 6)) send_char(label_byte());
            end
            send_char(TermCode);
        end else if (kind == 8) begin
            repeat ($urandom_range(0, 10))
                send_char(($urandom_range(0, 3) == 0) ? DotCode : label_byte());
            send_char(TermCode);
        end else begin
            // raw bytes, stray terminators included
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
            send_char(TermCode);
        end
    endtask

    // Reset capacity: extreme bytes, empty name, empty and trailing labels
    task automatic test_basic_names();
        send_char(8'hFF);
        send_char(DotCode);
        send_char(8'h01);
        send_char(TermCode);
        send_char(TermCode);
        send_name(".a");
        send_name("ab.");
    endtask

    // Overflow of characters, dots and terminators at the smallest capacities
    task automatic test_small_capacity();
        write_capacity(11'd2);
        send_name("a");
        send_name("a.");
        write_capacity(11'd3);
        send_name("a");
        write_capacity(11'd0);
        send_name("a");
        write_capacity(11'd1);
        send_char(TermCode);
    endtask

    // Saturated capacity: fill the buffer close to or up to its last address, or one past it
    task automatic test_full_buffer();
        write_capacity(11'h7FF);
        repeat (15) begin
            repeat (LabelMax) send_char(label_byte());
            send_char(DotCode);
        end
        repeat ($urandom_range(60, 63)) send_char(label_byte());
        send_char(TermCode);
    endtask

    task automatic test_random_names();
        int start_count;
        int target;
        int phase;
        start_count = counted_items;
        phase = 0;
        while (counted_items - start_count < RANDOM_ITEMS) begin
            // last stretch runs without idling on either side
            if (RANDOM_ITEMS - (counted_items - start_count) < QUIET_ITEMS) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            write_capacity(pick_capacity(phase));
            target = counted_items + PHASE_ITEMS;
            while (counted_items < target) begin
                send_random_name();
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
            phase++;
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.char_code = 8'd0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = 11'd0;
        capacity        = CapResetValue;
        seg_base        = 0;
        seg_chars       = 0;
        name_failed     = 1'b0;
        failures        = 0;
        counted_items   = 0;
        gaps_on         = 1'b1;
        stall_on        = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_names();
        test_small_capacity();
        test_full_buffer();
        test_random_names();

        drain_results();
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* dns_qname_label_encoder_core.f */
+incdir+rtl
rtl/dqle_pkg.sv
rtl/dqle_if.sv
rtl/dqle_encode.sv
rtl/dqle_fifo.sv
rtl/dns_qname_label_encoder_core.sv
bench/tb_dns_qname_label_encoder_core.sv
